FILE: hdl/led_enc_pkg.sv
// ============================================================================
// led_enc_pkg
// Register map, reset values and segment step codes of the LED serial encoder.
// ============================================================================
package led_enc_pkg;

    // Configuration register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_ZERO_HIGH  = 3'd0;
    localparam logic [2:0] REG_ONE_HIGH   = 3'd1;
    localparam logic [2:0] REG_BIT_PERIOD = 3'd2;
    localparam logic [2:0] REG_LATCH_LOW  = 3'd3;
    localparam logic [2:0] REG_BRIGHTNESS = 3'd4;
    localparam logic [2:0] REG_BLANK      = 3'd5;

    localparam int PADDR_W  = 5;
    localparam int TIME_W   = 10;
    localparam int LATCH_W  = 16;
    localparam int BRIGHT_W = 9;
    localparam int COLOR_W  = 8;
    localparam int PIXEL_W  = 3 * COLOR_W;

    localparam logic [TIME_W-1:0]   RST_ZERO_HIGH  = 10'd40;
    localparam logic [TIME_W-1:0]   RST_ONE_HIGH   = 10'd80;
    localparam logic [TIME_W-1:0]   RST_BIT_PERIOD = 10'd125;
    localparam logic [LATCH_W-1:0]  RST_LATCH_LOW  = 16'd8000;
    localparam logic [BRIGHT_W-1:0] RST_BRIGHTNESS = 9'd51;

    // Rounding offset and saturation limit of the brightness scaler
    localparam logic [17:0] ROUND_HALF = 18'd128;
    localparam logic [9:0]  COLOR_MAX  = 10'd255;

    // Segment steps of one pixel: leading latch, 24 data bits, trailing latch
    typedef logic [4:0] step_t;
    localparam step_t STEP_LEAD      = 5'd0;
    localparam step_t STEP_FIRST_BIT = 5'd1;
    localparam step_t STEP_LAST_BIT  = 5'd24;
    localparam step_t STEP_TRAIL     = 5'd25;

endpackage

FILE: hdl/led_serial_pixel_encoder_top.sv
// ============================================================================
// led_serial_pixel_encoder_top
// Turns pixels into timed pulse segments for a one-wire serial LED chain.
// ============================================================================
// Each pixel word (red, green, blue, last-of-frame on tlast) is scaled by the
// brightness register as (v*brightness + 128) >> 8, saturated at 255, or
// forced to zero while blank is set. It then leaves as 24 segment words, green,
// red, blue, MSB first; each word gives the high time (one_high_cycles or
// zero_high_cycles) and the low time (bit period minus high, floored at zero).
// A latch word (high 0, low latch_low_cycles, tuser 1) precedes the first pixel
// of a frame and follows the pixel that carries tlast. The master tlast marks
// the last segment word of each pixel. The segment sequencer emits one word per
// cycle when the output is not stalled, and a pixel gives 24 to 26 words;
// a one-pixel input register lets the next pixel in while the current one is
// still being sent. Configure only while the block is idle.
module led_serial_pixel_encoder_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    // APB configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [led_enc_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    // Pixel input
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [23:0]                       s_tdata,  // red[7:0], green[15:8], blue[23:16]
    input  logic                              s_tlast,  // last_pixel
    // Segment output
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [31:0]                       m_tdata,  // high_cycles[9:0], low_cycles[25:10]
    output logic                              m_tuser,  // is_latch
    output logic                              m_tlast   // run_end
);
    import led_enc_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [TIME_W-1:0]   zero_high_reg;
    logic [TIME_W-1:0]   one_high_reg;
    logic [TIME_W-1:0]   bit_period_reg;
    logic [LATCH_W-1:0]  latch_low_reg;
    logic [BRIGHT_W-1:0] brightness_reg;
    logic                blank_reg;

    logic       cfg_wr;
    logic [2:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_high_reg  <= RST_ZERO_HIGH;
            one_high_reg   <= RST_ONE_HIGH;
            bit_period_reg <= RST_BIT_PERIOD;
            latch_low_reg  <= RST_LATCH_LOW;
            brightness_reg <= RST_BRIGHTNESS;
            blank_reg      <= 1'b0;
        end
        else if (cfg_wr)
        begin
            // Writes beyond the register list fall through and are dropped
            unique case (cfg_idx)
                REG_ZERO_HIGH:  zero_high_reg  <= pwdata[TIME_W-1:0];
                REG_ONE_HIGH:   one_high_reg   <= pwdata[TIME_W-1:0];
                REG_BIT_PERIOD: bit_period_reg <= pwdata[TIME_W-1:0];
                REG_LATCH_LOW:  latch_low_reg  <= pwdata[LATCH_W-1:0];
                REG_BRIGHTNESS: brightness_reg <= pwdata[BRIGHT_W-1:0];
                REG_BLANK:      blank_reg      <= pwdata[0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_ZERO_HIGH:  prdata = {22'd0, zero_high_reg};
            REG_ONE_HIGH:   prdata = {22'd0, one_high_reg};
            REG_BIT_PERIOD: prdata = {22'd0, bit_period_reg};
            REG_LATCH_LOW:  prdata = {16'd0, latch_low_reg};
            REG_BRIGHTNESS: prdata = {23'd0, brightness_reg};
            REG_BLANK:      prdata = {31'd0, blank_reg};
            default:        prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pixel input register
    // ------------------------------------------------------------------
    logic [PIXEL_W-1:0] pix_data_reg;
    logic               pix_last_reg;
    logic               pix_valid_reg;

    // Sequencer state
    logic [PIXEL_W-1:0] bits_reg;       // GRB, next bit to send at the MSB
    step_t              step_reg;
    step_t              end_step_reg;
    logic               seq_busy_reg;
    logic               frame_open_reg;

    // Output register
    logic               out_valid_reg;
    logic [TIME_W-1:0]  out_high_reg;
    logic [LATCH_W-1:0] out_low_reg;
    logic               out_latch_reg;
    logic               out_end_reg;

    logic emit;
    logic seq_done;
    logic seq_load;

    assign emit     = seq_busy_reg && (!out_valid_reg || m_tready);
    assign seq_done = emit && (step_reg == end_step_reg);
    assign seq_load = pix_valid_reg && (!seq_busy_reg || seq_done);
    assign s_tready = !pix_valid_reg || seq_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            pix_valid_reg <= 1'b1;
        end
        else if (seq_load)
        begin
            pix_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            pix_data_reg <= s_tdata;
            pix_last_reg <= s_tlast;
        end
    end

    // ------------------------------------------------------------------
    // Brightness scaling of the held pixel
    // ------------------------------------------------------------------
    function automatic logic [COLOR_W-1:0] scale_color
    (
        input logic [COLOR_W-1:0]  v,
        input logic [BRIGHT_W-1:0] b,
        input logic                blk
    );
        logic [17:0] prod;
        logic [9:0]  rounded;
        prod    = 18'(v) * 18'(b) + ROUND_HALF;
        rounded = prod[17:8];
        if (blk)
            return '0;
        else if (rounded > COLOR_MAX)
            return COLOR_MAX[COLOR_W-1:0];
        else
            return rounded[COLOR_W-1:0];
    endfunction

    logic [COLOR_W-1:0] red_s;
    logic [COLOR_W-1:0] green_s;
    logic [COLOR_W-1:0] blue_s;

    assign red_s   = scale_color(pix_data_reg[7:0],   brightness_reg, blank_reg);
    assign green_s = scale_color(pix_data_reg[15:8],  brightness_reg, blank_reg);
    assign blue_s  = scale_color(pix_data_reg[23:16], brightness_reg, blank_reg);

    // ------------------------------------------------------------------
    // Segment sequencer: one segment word per cycle while the output is not stalled
    // ------------------------------------------------------------------
    logic               seg_latch;
    logic [TIME_W-1:0]  seg_high;
    logic [TIME_W-1:0]  bit_high;
    logic [TIME_W-1:0]  bit_low;
    logic [LATCH_W-1:0] seg_low;

    assign seg_latch = (step_reg == STEP_LEAD) || (step_reg == STEP_TRAIL);
    assign bit_high  = bits_reg[PIXEL_W-1] ? one_high_reg : zero_high_reg;
    // Floor the low time at zero when high outlasts the period
    assign bit_low   = (bit_period_reg > bit_high) ? (bit_period_reg - bit_high) : '0;
    assign seg_high  = seg_latch ? '0 : bit_high;
    assign seg_low   = seg_latch ? latch_low_reg : {{(LATCH_W-TIME_W){1'b0}}, bit_low};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_busy_reg   <= 1'b0;
            frame_open_reg <= 1'b0;
            step_reg       <= STEP_LEAD;
            end_step_reg   <= STEP_LAST_BIT;
        end
        else if (seq_load)
        begin
            // Open a frame with a latch word unless one is already running
            seq_busy_reg   <= 1'b1;
            step_reg       <= frame_open_reg ? STEP_FIRST_BIT : STEP_LEAD;
            end_step_reg   <= pix_last_reg ? STEP_TRAIL : STEP_LAST_BIT;
            frame_open_reg <= !pix_last_reg;
        end
        else if (seq_done)
        begin
            seq_busy_reg <= 1'b0;
        end
        else if (emit)
        begin
            step_reg <= step_reg + step_t'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq_load)
        begin
            bits_reg <= {green_s, red_s, blue_s};
        end
        else if (emit && !seg_latch)
        begin
            bits_reg <= {bits_reg[PIXEL_W-2:0], 1'b0};
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_high_reg  <= seg_high;
            out_low_reg   <= seg_low;
            out_latch_reg <= seg_latch;
            out_end_reg   <= (step_reg == end_step_reg);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_low_reg, out_high_reg};
    assign m_tuser  = out_latch_reg;
    assign m_tlast  = out_end_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_latch_no_high: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[TIME_W-1:0] == '0)
        else $error("latch word carries a high time");

    a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        seq_busy_reg |-> step_reg <= end_step_reg)
        else $error("sequencer ran past the end of its pixel");

    a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
        seq_load |=> seq_busy_reg && (step_reg == STEP_LEAD || step_reg == STEP_FIRST_BIT))
        else $error("pixel load did not start the sequencer");

    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        seq_load && pix_last_reg |=> !frame_open_reg && end_step_reg == STEP_TRAIL)
        else $error("last pixel did not close the frame");

endmodule
